// ===== rtl/core/bitmap_id_allocator_macros.svh =====
// assertion helpers for the checker file bmid_sva.sv
`ifndef BITMAP_ID_ALLOCATOR_MACROS_SVH
`define BITMAP_ID_ALLOCATOR_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define BMID_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// property that must hold in the cycle after its trigger
`define BMID_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== rtl/core/bmid_pkg.sv =====
`default_nettype none

package bmid_pkg;

  localparam int unsigned MAP_SLOTS_DEF = 4096;
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned BIT_IDX_W     = 6;

  localparam int unsigned ID_W     = 16;
  localparam int unsigned OFF_W    = 15;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 2;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [OFF_W-1:0]  ID_OFFSET_RST   = '0;
  localparam logic [SIZE_W-1:0] REGION_SIZE_RST = SIZE_W'(4096);

  typedef enum logic {
    REG_ID_OFFSET   = 1'b0,
    REG_REGION_SIZE = 1'b1
  } reg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_CHECK   = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_READ,
    S_COMMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic decide;
    logic read;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_stat_t;

  // index of the lowest set bit, binary search over halves
  function automatic logic [BIT_IDX_W-1:0] lowest_set(input logic [WORD_BITS-1:0] x);
    logic [WORD_BITS-1:0] v;
    logic [BIT_IDX_W-1:0] idx;
    v   = x;
    idx = '0;
    for (int k = BIT_IDX_W - 1; k >= 0; k--) begin
      if ((v & ((WORD_BITS'(1) << (1 << k)) - WORD_BITS'(1))) == '0) begin
        idx[k] = 1'b1;
        v      = v >> (1 << k);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bmid_regs.sv =====
`default_nettype none

module bmid_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bmid_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [bmid_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [bmid_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready,
  output logic      [bmid_pkg::OFF_W-1:0]       id_offset_o,
  output logic      [bmid_pkg::SIZE_W-1:0]      region_size_o
);

  logic [bmid_pkg::OFF_W-1:0]  id_offset_q;
  logic [bmid_pkg::SIZE_W-1:0] region_size_q;
  bmid_pkg::reg_idx_e          reg_idx;

  assign reg_idx = bmid_pkg::reg_idx_e'(paddr[bmid_pkg::APB_ADDR_W-1]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_offset_q   <= bmid_pkg::ID_OFFSET_RST;
      region_size_q <= bmid_pkg::REGION_SIZE_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        bmid_pkg::REG_ID_OFFSET:   id_offset_q   <= pwdata[bmid_pkg::OFF_W-1:0];
        bmid_pkg::REG_REGION_SIZE: region_size_q <= pwdata[bmid_pkg::SIZE_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      bmid_pkg::REG_ID_OFFSET:   prdata = bmid_pkg::APB_DATA_W'(id_offset_q);
      bmid_pkg::REG_REGION_SIZE: prdata = bmid_pkg::APB_DATA_W'(region_size_q);
    endcase
  end

  assign id_offset_o   = id_offset_q;
  assign region_size_o = region_size_q;

endmodule

`default_nettype wire

// ===== rtl/core/bmid_ctrl.sv =====
`default_nettype none

module bmid_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_tvalid_i,
  output logic                      s_tready_o,
  input  wire bmid_pkg::ctrl_stat_t stat_i,
  output bmid_pkg::ctrl_cmd_t       cmd_o
);

  bmid_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bmid_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      bmid_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.load = 1'b1;
          state_d    = bmid_pkg::S_DECIDE;
        end
      end
      bmid_pkg::S_DECIDE: begin
        cmd_o.decide = 1'b1;
        state_d      = bmid_pkg::S_READ;
      end
      bmid_pkg::S_READ: begin
        cmd_o.read = 1'b1;
        state_d    = bmid_pkg::S_COMMIT;
      end
      bmid_pkg::S_COMMIT: begin
        // hold here while the previous result is still unread
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = bmid_pkg::S_IDLE;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/bmid_dp.sv =====
`default_nettype none

module bmid_dp #(
  parameter int unsigned MAP_SLOTS = bmid_pkg::MAP_SLOTS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire bmid_pkg::ctrl_cmd_t            cmd_i,
  output bmid_pkg::ctrl_stat_t                stat_o,
  input  wire logic [bmid_pkg::MODE_W-1:0]    mode_i,
  input  wire logic [bmid_pkg::ID_W-1:0]      id_i,
  input  wire logic [bmid_pkg::OFF_W-1:0]     id_offset_i,
  input  wire logic [bmid_pkg::SIZE_W-1:0]    region_size_i,
  output logic                                m_tvalid_o,
  input  wire logic                           m_tready_i,
  output logic      [bmid_pkg::ID_W-1:0]      m_result_id_o,
  output logic      [bmid_pkg::STATUS_W-1:0]  m_status_o
);

  localparam int unsigned WB      = bmid_pkg::WORD_BITS;
  localparam int unsigned BW      = bmid_pkg::BIT_IDX_W;
  localparam int unsigned SW      = bmid_pkg::SIZE_W;
  localparam int unsigned IW      = bmid_pkg::ID_W;
  localparam int unsigned WORDS   = (MAP_SLOTS + WB - 1) / WB;
  localparam int unsigned WIDX_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned RANGE_W = IW + 1;
  localparam logic [SW-1:0] MAP_SLOTS_C = SW'(MAP_SLOTS);

  // captured request
  logic [bmid_pkg::MODE_W-1:0] mode_q;
  logic [IW-1:0]               id_q;
  bmid_pkg::mode_e             mode;

  // decided target
  logic [WIDX_W-1:0] addr_q;
  logic [BW-1:0]     bit_q;
  logic              ok_q;

  // bitmap store
  logic [WB-1:0]     mem_q [WORDS];
  logic [WORDS-1:0]  wvalid_q;
  logic [WB-1:0]     rdata_q;
  logic              rvalid_q;
  logic [WORDS-1:0]  has_free_q;

  // output register
  logic                        m_valid_q;
  logic [IW-1:0]               m_id_q;
  logic [bmid_pkg::STATUS_W-1:0] m_status_q;

  logic [SW-1:0]      eff_size;
  logic [SW-1:0]      lim_words;
  logic [WORDS-1:0]   below;
  logic [WORDS-1:0]   cand;
  logic               cand_any;
  logic [BW-1:0]      cand_w;
  logic [RANGE_W-1:0] lo, hi, id_ext;
  logic               in_range;
  logic [IW-1:0]      slot;

  logic [WB-1:0]      word;
  logic [SW-1:0]      n_left;
  logic [WB-1:0]      umask;
  logic [WB-1:0]      freebits;
  logic               free_any;
  logic [BW-1:0]      fb;
  logic               wr_en;
  logic [WB-1:0]      wdata;
  logic [IW-1:0]      res_id;
  bmid_pkg::status_e  status;
  logic               out_free;

  assign mode = bmid_pkg::mode_e'(mode_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      id_q   <= id_i;
    end
  end

  // decide stage: summary search and range test
  assign eff_size  = (region_size_i > MAP_SLOTS_C) ? MAP_SLOTS_C : region_size_i;
  assign lim_words = (eff_size + SW'(WB - 1)) >> BW;

  always_comb begin
    for (int w = 0; w < WORDS; w++) begin
      below[w] = SW'(w) < lim_words;
    end
  end

  assign cand     = has_free_q & below;
  assign cand_any = |cand;
  assign cand_w   = bmid_pkg::lowest_set(WB'(cand));

  assign lo       = RANGE_W'(id_offset_i);
  assign hi       = lo + RANGE_W'(eff_size);
  assign id_ext   = RANGE_W'(id_q);
  assign in_range = (id_ext >= lo) && (id_ext < hi);
  assign slot     = id_q - IW'(id_offset_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.decide) begin
      bit_q <= slot[BW-1:0];
      unique case (mode)
        bmid_pkg::MODE_ALLOC: begin
          addr_q <= cand_w[WIDX_W-1:0];
          ok_q   <= cand_any;
        end
        bmid_pkg::MODE_RELEASE, bmid_pkg::MODE_CHECK: begin
          addr_q <= slot[BW +: WIDX_W];
          ok_q   <= in_range;
        end
        default: begin
          addr_q <= '0;
          ok_q   <= 1'b0;
        end
      endcase
    end
  end

  // word memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rdata_q <= mem_q[addr_q];
    end
    if (wr_en) begin
      mem_q[addr_q] <= wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wvalid_q   <= '0;
      rvalid_q   <= 1'b0;
      has_free_q <= '1;
    end else begin
      if (cmd_i.read) begin
        rvalid_q <= wvalid_q[addr_q];
      end
      if (wr_en) begin
        wvalid_q[addr_q]   <= 1'b1;
        has_free_q[addr_q] <= ~&wdata;
      end
    end
  end

  // commit stage: modify the word and form the result
  assign word     = rvalid_q ? rdata_q : '0;
  assign n_left   = eff_size - (SW'(addr_q) << BW);
  assign umask    = (n_left >= SW'(WB)) ? '1 : ((WB'(1) << n_left[BW-1:0]) - WB'(1));
  assign freebits = ~word & umask;
  assign free_any = |freebits;
  assign fb       = bmid_pkg::lowest_set(freebits);
  assign out_free = !m_valid_q || m_tready_i;

  always_comb begin
    wr_en  = 1'b0;
    wdata  = word;
    res_id = '0;
    status = bmid_pkg::STATUS_OK;
    unique case (mode)
      bmid_pkg::MODE_ALLOC: begin
        if (ok_q && free_any) begin
          wdata  = word | (WB'(1) << fb);
          wr_en  = cmd_i.commit;
          res_id = IW'({addr_q, fb}) + IW'(id_offset_i);
        end else begin
          status = bmid_pkg::STATUS_FULL;
        end
      end
      bmid_pkg::MODE_RELEASE: begin
        if (ok_q) begin
          wdata = word & ~(WB'(1) << bit_q);
          wr_en = cmd_i.commit;
        end else begin
          status = bmid_pkg::STATUS_RANGE;
        end
      end
      bmid_pkg::MODE_CHECK: begin
        if (!ok_q) begin
          status = bmid_pkg::STATUS_RANGE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      m_id_q     <= res_id;
      m_status_q <= status;
    end
  end

  assign stat_o.out_free = out_free;
  assign m_tvalid_o      = m_valid_q;
  assign m_result_id_o   = m_id_q;
  assign m_status_o      = m_status_q;

endmodule

`default_nettype wire

// ===== rtl/core/bitmap_id_allocator.sv =====
`default_nettype none

// bitmap id allocator: hands out the lowest free slot below region_size as
// slot + id_offset (mode 0), frees the slot behind an in-range id (mode 1) and
// answers an id range test (mode 2); status 0 ok, 1 no free slot, 2 out of
// range, result id zero unless an allocation succeeds. each item goes from
// acceptance to the result register in these steps: accept, a search of the
// per-word free summary (or the range test), one read of the bitmap word
// memory and one write-back of that word; a new item is taken in the cycle
// after the result is registered, so no item is taken while the last one is
// still being worked on. a result left unread holds the next item in its
// write-back step until the output register frees up. the map is cleared
// by per-word valid bits at reset, so there is no clearing pass and items
// are accepted right after reset. the configuration registers may be
// written only while the block is idle.
module bitmap_id_allocator #(
  parameter int unsigned MAP_SLOTS = bmid_pkg::MAP_SLOTS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // request stream
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  input  wire logic [bmid_pkg::ID_W-1:0]        s_axis_tdata_i,   // [15:0] id
  input  wire logic [bmid_pkg::MODE_W-1:0]      s_axis_tuser_i,   // [1:0] mode
  // result stream
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  output logic      [bmid_pkg::ID_W-1:0]        m_axis_tdata_o,   // [15:0] result_id
  output logic      [bmid_pkg::STATUS_W-1:0]    m_axis_tuser_o,   // [1:0] status
  // configuration, id_offset at 0x0, region_size at 0x4
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [bmid_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [bmid_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [bmid_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                  pready
);

  logic [bmid_pkg::OFF_W-1:0]  id_offset;
  logic [bmid_pkg::SIZE_W-1:0] region_size;
  bmid_pkg::ctrl_cmd_t         cmd;
  bmid_pkg::ctrl_stat_t        stat;

  // register file
  bmid_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .id_offset_o   (id_offset),
    .region_size_o (region_size)
  );

  // sequencer: accept, decide, read, commit
  bmid_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // bitmap memory, free summary and result register
  bmid_dp #(
    .MAP_SLOTS (MAP_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mode_i        (s_axis_tuser_i),
    .id_i          (s_axis_tdata_i),
    .id_offset_i   (id_offset),
    .region_size_i (region_size),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready_i),
    .m_result_id_o (m_axis_tdata_o),
    .m_status_o    (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/bmid_sva.sv =====
`default_nettype none

`include "bitmap_id_allocator_macros.svh"

module bmid_sva (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          s_axis_tvalid_i,
  input wire logic                          s_axis_tready_o,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [bmid_pkg::ID_W-1:0]     m_axis_tdata_o,
  input wire logic [bmid_pkg::STATUS_W-1:0] m_axis_tuser_o
);

  logic in_acc;
  logic out_stall;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  `BMID_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready_o, "ready right after accept")
  `BMID_ASSERT_NOW(a_zero_id_on_fail, m_axis_tvalid_o && (m_axis_tuser_o != bmid_pkg::STATUS_OK), m_axis_tdata_o == '0, "nonzero id on failure")
  `BMID_ASSERT_NEXT(a_valid_holds, out_stall, m_axis_tvalid_o, "result dropped while stalled")
  `BMID_ASSERT_NEXT(a_payload_holds, out_stall, $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "result changed while stalled")

endmodule

bind bitmap_id_allocator bmid_sva u_bmid_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import bmid_pkg::*;

  localparam int unsigned MAP_SLOTS = MAP_SLOTS_DEF;
  // the spare tuser code, answered with status ok and no state change
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  // length of the forced result back-pressure stretch, in cycles
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  // random part: phases of traffic, each with its own register setting
  localparam int unsigned NUM_PHASES = 11;
  localparam int unsigned ITEMS_PER_PHASE = 102;

  typedef struct {
    logic [ID_W-1:0] result_id;
    status_e         status;
  } id_result_t;

  // bookkeeping of the slot map: shadow bitmap, register copies and the
  // results still owed by the block, oldest first
  class slot_bookkeeper;
    bit [MAP_SLOTS-1:0] used_slots;
    bit [OFF_W-1:0]     id_offset;
    bit [SIZE_W-1:0]    region_size;
    id_result_t         due_results[$];
    int unsigned        errors, n_items, n_granted, n_full, n_range, n_writes;

    function new();
      used_slots  = '0;
      id_offset   = ID_OFFSET_RST;
      region_size = REGION_SIZE_RST;
    endfunction

    function int unsigned usable_slots();
      return (region_size > MAP_SLOTS) ? MAP_SLOTS : region_size;
    endfunction

    function bit in_range(logic [ID_W-1:0] id);
      int unsigned lo, hi;
      lo = id_offset;
      hi = lo + usable_slots();
      return (id >= lo) && (id < hi);
    endfunction

    function void set_register(reg_idx_e idx, logic [APB_DATA_W-1:0] value);
      n_writes++;
      case (idx)
        REG_ID_OFFSET:   id_offset   = value[OFF_W-1:0];
        REG_REGION_SIZE: region_size = value[SIZE_W-1:0];
        default: ;
      endcase
    endfunction

    // an accepted request: update the map and queue the answer it must get
    function void take_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id);
      id_result_t  r;
      int unsigned lim;
      r.result_id = '0;
      r.status    = STATUS_OK;
      lim         = usable_slots();
      n_items++;
      case (mode)
        MODE_ALLOC: begin
          r.status = STATUS_FULL;
          for (int unsigned s = 0; s < lim; s++) begin
            if (!used_slots[s]) begin
              used_slots[s] = 1'b1;
              r.result_id   = ID_W'(s + id_offset);
              r.status      = STATUS_OK;
              break;
            end
          end
        end
        MODE_RELEASE: begin
          if (in_range(id)) used_slots[id - id_offset] = 1'b0;
          else r.status = STATUS_RANGE;
        end
        MODE_CHECK: begin
          if (!in_range(id)) r.status = STATUS_RANGE;
        end
        default: ;
      endcase
      if (mode == MODE_ALLOC && r.status == STATUS_OK) n_granted++;
      if (r.status == STATUS_FULL) n_full++;
      if (r.status == STATUS_RANGE) n_range++;
      due_results.push_back(r);
    endfunction

    function void match_result(logic [ID_W-1:0] rid, logic [STATUS_W-1:0] st);
      id_result_t want;
      if (due_results.size() == 0) begin
        $display("%0t: result with none due: result_id %h status %0d", $time, rid, st);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (rid !== want.result_id) begin
        $display("%0t: result_id mismatch: expected %h, got %h", $time, want.result_id, rid);
        errors++;
      end
      if (st !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, st);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return due_results.size();
    endfunction

    // an id whose slot is taken right now, so releases mostly hit
    function logic [ID_W-1:0] pick_used_id();
      int unsigned lim, start, s;
      lim = usable_slots();
      if (lim == 0) return ID_W'($urandom);
      start = $urandom_range(0, lim - 1);
      for (int unsigned k = 0; k < lim; k++) begin
        s = (start + k) % lim;
        if (used_slots[s]) return ID_W'(s + id_offset);
      end
      return ID_W'(start + id_offset);
    endfunction

    // an id in the range or one step outside either bound
    function logic [ID_W-1:0] pick_near_id();
      return ID_W'(id_offset + $urandom_range(0, usable_slots() + 1) - 1);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [ID_W-1:0]       s_axis_tdata_i = '0;   // [15:0] id
  logic [MODE_W-1:0]     s_axis_tuser_i = '0;   // [1:0] mode
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [ID_W-1:0]       m_axis_tdata_o;        // [15:0] result_id
  logic [STATUS_W-1:0]   m_axis_tuser_o;        // [1:0] status
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  slot_bookkeeper pool = new();
  bit             sender_eager = 1'b0;     // phase without input gaps
  bit             hold_results_req = 1'b0; // asks the sink for a long stall

  bitmap_id_allocator #(
    .MAP_SLOTS(MAP_SLOTS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // both handshakes seen at the rising edge, before the block updates
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) pool.take_request(s_axis_tuser_i, s_axis_tdata_i);
      if (m_axis_tvalid_o && m_axis_tready_i) pool.match_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  // result sink: runs of readiness and stalls, plus the forced long stall
  initial begin : result_sink
    int unsigned run_len, stall_len;
    wait (rst_ni);
    forever begin
      if (hold_results_req) begin
        @(negedge clk_i) m_axis_tready_i <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk_i);
        hold_results_req = 1'b0;
      end
      // some stretches with no stall at all
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 16);
      @(negedge clk_i) m_axis_tready_i <= 1'b1;
      repeat (run_len - 1) @(negedge clk_i);
      stall_len = pick_gap();
      if (stall_len != 0) begin
        @(negedge clk_i) m_axis_tready_i <= 1'b0;
        repeat (stall_len - 1) @(negedge clk_i);
      end
    end
  end

  // offer one request and hold it until taken; valid stays up if no gap follows
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= mode;
    s_axis_tdata_i  <= id;
    do @(posedge clk_i); while (!s_axis_tready_o);
    gap = sender_eager ? 0 : pick_gap();
    if (gap != 0) begin
      @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // sender stops and waits for every owed result
  task automatic wait_results_drained();
    @(negedge clk_i) s_axis_tvalid_i <= 1'b0;
    while (pool.outstanding() != 0) @(posedge clk_i);
  endtask

  // setup cycle, then access cycle; register taken at the access edge
  task automatic write_register(input reg_idx_e idx, input logic [APB_DATA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pool.set_register(idx, value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mostly allocations and releases of live ids, some stray ids and spare codes
  task automatic send_random_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40)      send_request(MODE_ALLOC, ID_W'($urandom));
    else if (r < 68) send_request(MODE_RELEASE, pool.pick_used_id());
    else if (r < 76) send_request(MODE_RELEASE, ID_W'($urandom));
    else if (r < 86) send_request(MODE_CHECK, pool.pick_near_id());
    else if (r < 95) send_request(MODE_CHECK, ID_W'($urandom));
    else             send_request(MODE_SPARE, ID_W'($urandom));
  endtask

  // new register setting per phase, extremes and small regions favored
  task automatic pick_setting();
    logic [APB_DATA_W-1:0] offset_val, size_val;
    case ($urandom_range(0, 3))
      0:       offset_val = 0;
      1:       offset_val = 32767;
      default: offset_val = $urandom;
    endcase
    case ($urandom_range(0, 9))
      0:       size_val = 0;
      1:       size_val = 1;
      2:       size_val = 2;
      3:       size_val = 64;
      4:       size_val = MAP_SLOTS;
      5:       size_val = 8191;
      9:       size_val = $urandom;
      default: size_val = $urandom_range(3, 200);
    endcase
    write_register(REG_ID_OFFSET, offset_val);
    write_register(REG_REGION_SIZE, size_val);
  endtask

  initial begin : stimulus
    repeat (5) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // reset setting: offset 0, full map
    send_request(MODE_ALLOC, 16'hFFFF);       // slot 0, id field ignored
    send_request(MODE_ALLOC, 16'h0000);
    send_request(MODE_ALLOC, 16'h5A5A);
    send_request(MODE_CHECK, 16'd0);          // lower bound inside
    send_request(MODE_CHECK, 16'd4095);       // last id inside
    send_request(MODE_CHECK, 16'd4096);       // upper bound is exclusive
    send_request(MODE_CHECK, 16'hFFFF);
    send_request(MODE_RELEASE, 16'd1);
    send_request(MODE_ALLOC, 16'd0);          // freed slot comes back first
    send_request(MODE_RELEASE, 16'd1000);     // slot already free, still ok
    send_request(MODE_RELEASE, 16'hFFFF);     // out of range
    send_request(MODE_SPARE, 16'hFFFF);
    send_request(MODE_SPARE, 16'h0000);
    wait_results_drained();

    // largest offset with an empty region: nothing usable
    write_register(REG_ID_OFFSET, 32'd32767);
    write_register(REG_REGION_SIZE, 32'd0);
    send_request(MODE_ALLOC, 16'd0);
    send_request(MODE_CHECK, 16'd32767);
    send_request(MODE_RELEASE, 16'd32767);
    wait_results_drained();

    // region beyond the map saturates to the map size
    write_register(REG_REGION_SIZE, 32'd8191);
    send_request(MODE_ALLOC, 16'd0);
    send_request(MODE_CHECK, 16'd36862);
    send_request(MODE_CHECK, 16'd36863);
    send_request(MODE_CHECK, 16'd32766);
    wait_results_drained();

    // region shrunk under used slots: full, and slot 2 can't be released
    write_register(REG_REGION_SIZE, 32'd1);
    send_request(MODE_ALLOC, 16'd0);
    send_request(MODE_RELEASE, 16'd32769);
    wait_results_drained();

    // region grown again, slot 2 releasable and reused
    write_register(REG_REGION_SIZE, MAP_SLOTS);
    send_request(MODE_RELEASE, 16'd32769);
    send_request(MODE_ALLOC, 16'd0);
    wait_results_drained();

    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      pick_setting();
      sender_eager = ($urandom_range(0, 3) == 0);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (ph == 2 && n == 10) begin
          // sink stalls long while requests keep coming, input must back up
          hold_results_req = 1'b1;
          do send_random_request(); while (hold_results_req);
        end
        send_random_request();
        // occasional pause until everything owed has come back
        if ($urandom_range(0, 49) == 0) wait_results_drained();
      end
      wait_results_drained();
    end

    wait_results_drained();
    repeat (20) @(posedge clk_i);
    $display("covered %0d requests over %0d register writes: %0d ids granted,",
             pool.n_items, pool.n_writes, pool.n_granted);
    $display("  %0d answers with region full, %0d with id out of range",
             pool.n_full, pool.n_range);
    if (pool.errors == 0 && pool.outstanding() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin : watchdog
    #20_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

// ===== bitmap_id_allocator.f =====
+incdir+rtl/core
rtl/core/bmid_pkg.sv
rtl/core/bmid_regs.sv
rtl/core/bmid_ctrl.sv
rtl/core/bmid_dp.sv
rtl/core/bitmap_id_allocator.sv
rtl/core/bmid_sva.sv
tb/testbench.sv
